[hdl/mwamm_pkg.sv]
// ----------------------------------------------------------------------------
// mwamm_pkg
// Shared constants, controller states and the command and status bundles
// that pass between the controller and the datapath of the moving window
// average block.
// ----------------------------------------------------------------------------
package mwamm_pkg;

   // Default window depth
   localparam int unsigned WINDOW_DEF = 64;

   // Fixed payload widths
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned COUNT_W  = 7;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;    // capture the sample, start the window read
      logic update;    // fold the sample into the window state
      logic div_load;  // load the divider from the window sum
      logic div_step;  // one radix-2 divide step
      logic out_load;  // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_last;  // the current divide step is the final one
   } status_type;

endpackage

[hdl/mwamm_req_if.sv]
// ----------------------------------------------------------------------------
// mwamm_req_if
// Sample channel: valid/ready handshake carrying one signed sample.
// ----------------------------------------------------------------------------
interface mwamm_req_if;
   import mwamm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);

endinterface

[hdl/mwamm_rsp_if.sv]
// ----------------------------------------------------------------------------
// mwamm_rsp_if
// Result channel: valid/ready handshake carrying average, minimum, maximum
// and window count.
// ----------------------------------------------------------------------------
interface mwamm_rsp_if;
   import mwamm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] average;
   logic signed [SAMPLE_W-1:0] minimum;
   logic signed [SAMPLE_W-1:0] maximum;
   logic        [COUNT_W-1:0]  count;

   modport source (output valid, output average, output minimum, output maximum,
                   output count, input ready);
   modport sink   (input valid, input average, input minimum, input maximum,
                   input count, output ready);

endinterface

[hdl/mwamm_ram.sv]
// ----------------------------------------------------------------------------
// mwamm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mwamm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mwamm_ctrl.sv]
// ----------------------------------------------------------------------------
// mwamm_ctrl
// Controller: sequences window read, state update, serial divide and result
// hand-off, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module mwamm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mwamm_pkg::cmd_type    cmd,
   input  mwamm_pkg::status_type status
);
   import mwamm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result register may be loaded when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_UPDATE: cmd.update   = 1'b1;
         ST_LOAD:   cmd.div_load = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_DONE:   cmd.out_load = out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   // Result valid: set on load, drop on transfer
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/mwamm_datapath.sv]
// ----------------------------------------------------------------------------
// mwamm_datapath
// Datapath: window RAM, running sum, fill count, all-time min and max,
// restoring radix-2 divider and the result register.
// ----------------------------------------------------------------------------
module mwamm_datapath #(
   parameter int unsigned WINDOW = mwamm_pkg::WINDOW_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mwamm_pkg::cmd_type                      cmd,
   output mwamm_pkg::status_type                   status,
   input  logic signed [mwamm_pkg::SAMPLE_W-1:0]  req_sample,
   output logic signed [mwamm_pkg::SAMPLE_W-1:0]  rsp_average,
   output logic signed [mwamm_pkg::SAMPLE_W-1:0]  rsp_minimum,
   output logic signed [mwamm_pkg::SAMPLE_W-1:0]  rsp_maximum,
   output logic        [mwamm_pkg::COUNT_W-1:0]   rsp_count
);
   import mwamm_pkg::*;

   localparam int unsigned PTR_W  = $clog2(WINDOW);
   localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
   localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int unsigned STEP_W = $clog2(SUM_W);

   localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(WINDOW);
   localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(SUM_W - 1);

   // Window state
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic        [PTR_W-1:0]    wptr_ff, wptr_in;
   logic        [CNT_W-1:0]    fill_ff, fill_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic        [SAMPLE_W-1:0] old_raw;
   logic signed [SUM_W-1:0]    drop_term;
   logic                       full;

   // Divider
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    trial_diff;
   logic              trial_ok;

   // Result register
   logic signed [SAMPLE_W-1:0] avg_ff;
   logic signed [SAMPLE_W-1:0] res_min_ff;
   logic signed [SAMPLE_W-1:0] res_max_ff;
   logic        [COUNT_W-1:0]  res_cnt_ff;
   logic        [SAMPLE_W-1:0] avg_in;

   // Window store: read the oldest slot on transfer, overwrite it on update
   mwamm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (wptr_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.accept),
      .rd_addr (wptr_ff),
      .rd_data (old_raw)
   );

   // Hold the sample for the duration of the item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
   end

   // Window sum, fill count and write pointer
   assign full      = (fill_ff == CNT_FULL);
   assign drop_term = full ? SUM_W'($signed(old_raw)) : '0;

   always_comb begin
      wptr_in = wptr_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (cmd.update) begin
         sum_in  = sum_ff - drop_term + SUM_W'(sample_ff);
         fill_in = full ? fill_ff : fill_ff + 1'b1;
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
   end

   // All-time min and max; the first sample sets both
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.update) begin
         if (fill_ff == '0) begin
            min_in = sample_ff;
            max_in = sample_ff;
         end else if (sample_ff < min_ff) begin
            min_in = sample_ff;
         end else if (sample_ff > max_ff) begin
            max_in = sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         min_ff  <= '0;
         max_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
      end
   end

   // Restoring divide of the sum magnitude by the fill count, one bit a step
   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_diff = trial - {1'b0, fill_ff};
   assign trial_ok   = (trial >= {1'b0, fill_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      if (cmd.div_load) begin
         neg_in  = sum_ff[SUM_W-1];
         quo_in  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in  = '0;
         step_in = STEP_FIRST;
      end else if (cmd.div_step) begin
         quo_in  = {quo_ff[SUM_W-2:0], trial_ok};
         rem_in  = trial_ok ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
   end

   assign status.div_last = (step_ff == '0);

   // Restore the sign and load the result register
   assign avg_in = neg_ff ? -quo_ff[SAMPLE_W-1:0] : quo_ff[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         avg_ff     <= avg_in;
         res_min_ff <= min_ff;
         res_max_ff <= max_ff;
         res_cnt_ff <= COUNT_W'(fill_ff);
      end
   end

   assign rsp_average = avg_ff;
   assign rsp_minimum = res_min_ff;
   assign rsp_maximum = res_max_ff;
   assign rsp_count   = res_cnt_ff;

endmodule

[hdl/moving_window_average_min_max.sv]
// Moving window average with all-time minimum and maximum. Each sample
// transfer yields one result: the average of the last WINDOW samples (or of
// all samples so far until the window fills), truncated toward zero, the
// smallest and largest sample since reset, and the window count. The
// restoring divider produces one quotient bit per cycle over the width of
// the window sum. A new sample is taken while the previous result still
// waits in the output register.
// ----------------------------------------------------------------------------
// moving_window_average_min_max
// Top level: joins the controller and the datapath to the sample and result
// channels.
// ----------------------------------------------------------------------------
module moving_window_average_min_max #(
   parameter int unsigned WINDOW = mwamm_pkg::WINDOW_DEF
) (
   input logic          clock,
   input logic          reset,
   mwamm_req_if.sink    req_ch,
   mwamm_rsp_if.source  rsp_ch
);
   import mwamm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing and handshakes
   mwamm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Window state, divider and result register
   mwamm_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_ch.sample),
      .rsp_average (rsp_ch.average),
      .rsp_minimum (rsp_ch.minimum),
      .rsp_maximum (rsp_ch.maximum),
      .rsp_count   (rsp_ch.count)
   );

endmodule

[bench/tb_moving_window_average_min_max.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_window_average_min_max
// Drives signed samples into the moving window block and checks every result
// against a behavioural window: ring of samples, running sum, saturating
// count, truncating average and all-time minimum and maximum. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_moving_window_average_min_max;
   import mwamm_pkg::*;

   localparam int unsigned WINDOW      = WINDOW_DEF;
   localparam int unsigned N_RANDOM    = 1500;
   localparam int unsigned SETTLE      = 80;
   localparam int unsigned HOLD_AFTER  = 400;
   localparam int unsigned HOLD_CYCLES = 600;
   localparam int unsigned MAX_REPORTS = 10;
   localparam real         HALF_PERIOD = 2.0;
   localparam real         LIMIT_NS    = 4000000.0;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic signed [SAMPLE_W-1:0] minimum;
      logic signed [SAMPLE_W-1:0] maximum;
      logic        [COUNT_W-1:0]  count;
   } stats_type;

   // Sample patterns for the random segments
   typedef enum int unsigned {
      PAT_SPREAD,
      PAT_CLUSTER,
      PAT_EDGE,
      PAT_FULL
   } pattern_type;

   // Window statistics tracker: holds its own ring, sum and extremes and
   // queues the statistics each sample transfer should produce
   class window_stats_board;
      logic signed [SAMPLE_W-1:0] ring [WINDOW];
      int unsigned                slot;
      int unsigned                fill;
      longint                     sum;
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
      stats_type                  due [$];
      int unsigned                errors;

      function new();
         slot   = 0;
         fill   = 0;
         sum    = 0;
         lo     = '0;
         hi     = '0;
         errors = 0;
      endfunction

      // Fold one sample into the window and queue the statistics it yields
      function void note_sample(logic signed [SAMPLE_W-1:0] s);
         stats_type want;
         longint    quot;
         if (fill < WINDOW) begin
            fill++;
         end else begin
            sum -= longint'(ring[slot]);
         end
         ring[slot] = s;
         sum += longint'(s);
         slot = (slot + 1) % WINDOW;
         // SystemVerilog division truncates toward zero
         quot = sum / longint'(fill);
         if (fill == 1) begin
            lo = s;
            hi = s;
         end else if (s < lo) begin
            lo = s;
         end else if (s > hi) begin
            hi = s;
         end
         want.average = quot[SAMPLE_W-1:0];
         want.minimum = lo;
         want.maximum = hi;
         want.count   = fill[COUNT_W-1:0];
         due.push_back(want);
      endfunction

      function void flag(string what, logic signed [63:0] want_v, logic signed [63:0] got_v);
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
         end
      endfunction

      // Compare one result transfer with the oldest queued statistics
      function void check_result(stats_type got);
         stats_type want;
         if (due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected result: average %0d min %0d max %0d count %0d",
                        got.average, got.minimum, got.maximum, got.count);
            end
            return;
         end
         want = due.pop_front();
         if (got.average !== want.average) flag("average", want.average, got.average);
         if (got.minimum !== want.minimum) flag("minimum", want.minimum, got.minimum);
         if (got.maximum !== want.maximum) flag("maximum", want.maximum, got.maximum);
         if (got.count !== want.count) flag("count", want.count, got.count);
      endfunction

      function int unsigned pending();
         return due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   bit   rsp_held = 1'b0;

   mwamm_req_if req_bus ();
   mwamm_rsp_if rsp_bus ();

   window_stats_board board = new();

   moving_window_average_min_max #(
      .WINDOW (WINDOW)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   // Random sample of at most the given magnitude width, either sign
   function automatic logic signed [SAMPLE_W-1:0] rand_sample(int unsigned bits);
      logic [SAMPLE_W-1:0] raw;
      raw = $urandom;
      if (bits < SAMPLE_W) begin
         raw &= (32'h1 << bits) - 32'h1;
         if ($urandom_range(0, 1) == 1) raw = -raw;
      end
      return raw;
   endfunction

   // Offer one sample, wait for its transfer, then idle for a while
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int unsigned gap;
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      do @(posedge clock); while (!req_bus.ready);
      board.note_sample(s);
      gap = (steady || rsp_held) ? 0 : idle_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sample side
   initial begin : stimulus
      int unsigned                sent;
      int unsigned                seg_len;
      int unsigned                bits;
      pattern_type                pat;
      logic signed [SAMPLE_W-1:0] base;
      logic signed [SAMPLE_W-1:0] s;
      longint                     mag;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Opening: a negative first sample sets both extremes, then ties,
      // in-between values and a negative average that must truncate upward
      send_sample(-5);
      send_sample(7);
      send_sample(-9);
      send_sample(12);
      send_sample(-9);
      send_sample(12);
      send_sample(3);
      send_sample(-3);
      send_sample(-1);
      send_sample(1);
      send_sample(0);
      send_sample(-20);
      send_sample(25);

      // Random segments: magnitude widens as the run goes on so the
      // all-time extremes keep moving; full range only in the last third
      sent = 0;
      while (sent < N_RANDOM) begin
         seg_len = $urandom_range(20, 120);
         pat     = pattern_type'($urandom_range(0, 3));
         steady  = ($urandom_range(0, 3) == 0);
         bits    = 4 + (sent * 28) / N_RANDOM;
         if (pat == PAT_FULL && sent < (N_RANDOM * 2) / 3) pat = PAT_SPREAD;
         base = rand_sample(bits);
         repeat (seg_len) begin
            case (pat)
               PAT_SPREAD: begin
                  s = rand_sample(bits);
               end
               PAT_CLUSTER: begin
                  s = base + rand_sample(3);
               end
               PAT_EDGE: begin
                  mag = (longint'(1) << bits) - 1 - $urandom_range(0, 3);
                  if ($urandom_range(0, 1) == 1) mag = -mag;
                  s = mag[SAMPLE_W-1:0];
               end
               default: begin
                  s = rand_sample(SAMPLE_W);
               end
            endcase
            send_sample(s);
            sent++;
         end
      end
      steady = 1'b0;

      // Closing: full windows of each extreme, then alternation and bit patterns
      repeat (WINDOW + 6) send_sample(SAMPLE_MAX);
      repeat (WINDOW + 6) send_sample(SAMPLE_MIN);
      repeat (10) begin
         send_sample(SAMPLE_MAX);
         send_sample(SAMPLE_MIN);
      end
      send_sample(32'sh5555_5555);
      send_sample(32'shAAAA_AAAA);
      send_sample(-1);
      send_sample(0);
      req_bus.valid <= 1'b0;

      // Drain, then let the divider run out before judging
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.pending() != 0) board.errors += board.pending();
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Result side: random ready pattern with one long hold-off
   initial begin : result_side
      int unsigned run;
      int unsigned stall;
      int unsigned taken;
      bit          held_once;
      stats_type   got;
      taken     = 0;
      held_once = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = steady ? 40 : $urandom_range(1, 30);
         rsp_bus.ready <= 1'b1;
         repeat (run) begin
            @(posedge clock);
            if (rsp_bus.valid && rsp_bus.ready) begin
               got.average = rsp_bus.average;
               got.minimum = rsp_bus.minimum;
               got.maximum = rsp_bus.maximum;
               got.count   = rsp_bus.count;
               board.check_result(got);
               taken++;
            end
         end
         // Hold off once so the block fills and stalls the sample side
         if (!held_once && taken >= HOLD_AFTER) begin
            held_once = 1'b1;
            rsp_held  = 1'b1;
            stall     = HOLD_CYCLES;
         end else begin
            stall = steady ? 0 : idle_gap();
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_held = 1'b0;
      end
   end

   // Run limit
   initial begin : watchdog
      #(LIMIT_NS * 1ns);
      $display("tb: failure");
      $finish;
   end

endmodule
